### design/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg: shared types and constants for the 3D segment intersection block
// Fixed port widths and the sideband record carried down the pipeline.
// ----------------------------------------------------------------------------
package sid_pkg;

  // width of every input coordinate port
  localparam int IN_W = 16;
  // width of every Q-format output coordinate
  localparam int PT_W = 32;

  // axis count
  localparam int AXES = 3;

  // sideband that travels with each item through the divider
  typedef struct packed {
    logic                       hit;  // segments meet
    logic                       gen;  // point comes from the divider
    logic [AXES-1:0]            neg;  // sign of dB per axis
    logic [AXES-1:0][PT_W-1:0]  pt;   // point when not from the divider
    logic [AXES-1:0][PT_W-1:0]  bsf;  // B.start in fixed point
  } side_t;

endpackage

### design/sid_front.sv
// ----------------------------------------------------------------------------
// sid_front: geometry front end
// Six register stages: differences, products, cross/dot sums, case tests,
// normalization, range test and the dividend products for the divider.
// ----------------------------------------------------------------------------
module sid_front #(
  parameter int CW = 16,
  parameter int FW = 16,
  localparam int DW   = CW + 1,
  localparam int PW   = 2 * DW,
  localparam int XW   = PW + 1,
  localparam int DOTW = PW + 2,
  localparam int CDW  = XW + DW,
  localparam int CSW  = CDW + 2,
  localparam int UW   = PW,
  localparam int PRW  = UW + CW
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_vld,
  input  logic [3:0][sid_pkg::AXES-1:0][sid_pkg::IN_W-1:0] in_pts,
  output logic                                        out_vld,
  output sid_pkg::side_t                              out_side,
  output logic [UW-1:0]                               out_den,
  output logic [sid_pkg::AXES-1:0][PRW-1:0]           out_prod
);

  localparam int PW32 = sid_pkg::PT_W;

  // --------------------------------------------------------------------------
  // stage A: sign-extend, differences, degeneracy, fixed-point endpoints
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]   crd [4][3];
  logic signed [DW-1:0]   da_nxt [3], db_nxt [3], d3_nxt [3], w2_nxt [3];

  logic                   vld_a_r;
  logic signed [DW-1:0]   da_a_r [3], db_a_r [3], d3_a_r [3], w2_a_r [3];
  logic                   dga_a_r, dgb_a_r, eqab_a_r;
  logic signed [PW32-1:0] asf_a_r [3], aef_a_r [3], bsf_a_r [3];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 3; i++) begin
        crd[p][i] = $signed(in_pts[p][i][CW-1:0]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      da_nxt[i] = DW'(crd[1][i]) - DW'(crd[0][i]);
      db_nxt[i] = DW'(crd[3][i]) - DW'(crd[2][i]);
      d3_nxt[i] = DW'(crd[2][i]) - DW'(crd[0][i]);
      w2_nxt[i] = DW'(crd[1][i]) - DW'(crd[2][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      da_a_r[i]  <= da_nxt[i];
      db_a_r[i]  <= db_nxt[i];
      d3_a_r[i]  <= d3_nxt[i];
      w2_a_r[i]  <= w2_nxt[i];
      asf_a_r[i] <= PW32'(crd[0][i]) <<< FW;
      aef_a_r[i] <= PW32'(crd[1][i]) <<< FW;
      bsf_a_r[i] <= PW32'(crd[2][i]) <<< FW;
    end
    dga_a_r  <= (crd[0][0] == crd[1][0]) && (crd[0][1] == crd[1][1]) &&
                (crd[0][2] == crd[1][2]);
    dgb_a_r  <= (crd[2][0] == crd[3][0]) && (crd[2][1] == crd[3][1]) &&
                (crd[2][2] == crd[3][2]);
    eqab_a_r <= (crd[0][0] == crd[2][0]) && (crd[0][1] == crd[2][1]) &&
                (crd[0][2] == crd[2][2]);
  end

  // --------------------------------------------------------------------------
  // stage B: all pairwise products
  // crosses: 0 dA x dB, 1 d3 x dA, 2 d3 x dB, 3 dB x (A.end - B.start)
  // dots:    0 d3.dB, 1 dB.dB, 2 (A.end - B.start).dB, 3 d3.dA, 4 dA.dA
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] cu [4][3], cv [4][3], du [5][3], dv [5][3];

  logic                   vld_b_r;
  logic signed [PW-1:0]   xp_b_r [4][3][2];
  logic signed [PW-1:0]   dp_b_r [5][3];
  logic signed [DW-1:0]   d3_b_r [3];
  logic [CW-1:0]          m_b_r [3];
  logic [2:0]             neg_b_r;
  logic                   dga_b_r, dgb_b_r, eqab_b_r;
  logic signed [PW32-1:0] asf_b_r [3], aef_b_r [3], bsf_b_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cu[0][i] = da_a_r[i]; cv[0][i] = db_a_r[i];
      cu[1][i] = d3_a_r[i]; cv[1][i] = da_a_r[i];
      cu[2][i] = d3_a_r[i]; cv[2][i] = db_a_r[i];
      cu[3][i] = db_a_r[i]; cv[3][i] = w2_a_r[i];
      du[0][i] = d3_a_r[i]; dv[0][i] = db_a_r[i];
      du[1][i] = db_a_r[i]; dv[1][i] = db_a_r[i];
      du[2][i] = w2_a_r[i]; dv[2][i] = db_a_r[i];
      du[3][i] = d3_a_r[i]; dv[3][i] = da_a_r[i];
      du[4][i] = da_a_r[i]; dv[4][i] = da_a_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int x = 0; x < 4; x++) begin
      for (int i = 0; i < 3; i++) begin
        xp_b_r[x][i][0] <= PW'(cu[x][(i+1)%3]) * PW'(cv[x][(i+2)%3]);
        xp_b_r[x][i][1] <= PW'(cu[x][(i+2)%3]) * PW'(cv[x][(i+1)%3]);
      end
    end
    for (int d = 0; d < 5; d++) begin
      for (int i = 0; i < 3; i++) begin
        dp_b_r[d][i] <= PW'(du[d][i]) * PW'(dv[d][i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      d3_b_r[i]  <= d3_a_r[i];
      neg_b_r[i] <= db_a_r[i][DW-1];
      m_b_r[i]   <= db_a_r[i][DW-1] ? CW'(-db_a_r[i]) : CW'(db_a_r[i]);
      asf_b_r[i] <= asf_a_r[i];
      aef_b_r[i] <= aef_a_r[i];
      bsf_b_r[i] <= bsf_a_r[i];
    end
    dga_b_r  <= dga_a_r;
    dgb_b_r  <= dgb_a_r;
    eqab_b_r <= eqab_a_r;
  end

  // --------------------------------------------------------------------------
  // stage C: cross and dot sums
  // --------------------------------------------------------------------------
  logic                   vld_c_r;
  logic signed [XW-1:0]   xs_c_r [4][3];
  logic signed [DOTW-1:0] ds_c_r [5];
  logic signed [DW-1:0]   d3_c_r [3];
  logic [CW-1:0]          m_c_r [3];
  logic [2:0]             neg_c_r;
  logic                   dga_c_r, dgb_c_r, eqab_c_r;
  logic signed [PW32-1:0] asf_c_r [3], aef_c_r [3], bsf_c_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int x = 0; x < 4; x++) begin
      for (int i = 0; i < 3; i++) begin
        xs_c_r[x][i] <= XW'(xp_b_r[x][i][0]) - XW'(xp_b_r[x][i][1]);
      end
    end
    for (int d = 0; d < 5; d++) begin
      ds_c_r[d] <= DOTW'(dp_b_r[d][0]) + DOTW'(dp_b_r[d][1]) + DOTW'(dp_b_r[d][2]);
    end
    for (int i = 0; i < 3; i++) begin
      d3_c_r[i]  <= d3_b_r[i];
      m_c_r[i]   <= m_b_r[i];
      asf_c_r[i] <= asf_b_r[i];
      aef_c_r[i] <= aef_b_r[i];
      bsf_c_r[i] <= bsf_b_r[i];
    end
    neg_c_r  <= neg_b_r;
    dga_c_r  <= dga_b_r;
    dgb_c_r  <= dgb_b_r;
    eqab_c_r <= eqab_b_r;
  end

  // --------------------------------------------------------------------------
  // stage D: point-on-segment tests, degenerate and parallel answers,
  // coplanarity products, axis pick
  // --------------------------------------------------------------------------
  logic                   os1, os2, os3, cz;
  logic                   degh_nxt, parh_nxt;
  logic signed [PW32-1:0] degpt_nxt [3], parpt_nxt [3];
  logic [1:0]             k;

  logic                   vld_d_r;
  logic signed [CDW-1:0]  cd_d_r [3];
  logic                   deg_d_r, degh_d_r, cz_d_r, parh_d_r;
  logic signed [PW32-1:0] degpt_d_r [3], parpt_d_r [3], bsf_d_r [3];
  logic signed [XW-1:0]   den_d_r, num_d_r, snum_d_r;
  logic [CW-1:0]          m_d_r [3];
  logic [2:0]             neg_d_r;

  always_comb begin
    // A.start on B: dB x (A.start - B.start) equals d3 x dB
    os1 = (xs_c_r[2][0] == '0) && (xs_c_r[2][1] == '0) && (xs_c_r[2][2] == '0) &&
          (ds_c_r[0] <= 0) && (-ds_c_r[0] <= ds_c_r[1]);
    // A.end on B
    os2 = (xs_c_r[3][0] == '0) && (xs_c_r[3][1] == '0) && (xs_c_r[3][2] == '0) &&
          (ds_c_r[2] >= 0) && (ds_c_r[2] <= ds_c_r[1]);
    // B.start on A: dA x d3 is the negated d3 x dA
    os3 = (xs_c_r[1][0] == '0) && (xs_c_r[1][1] == '0) && (xs_c_r[1][2] == '0) &&
          (ds_c_r[3] >= 0) && (ds_c_r[3] <= ds_c_r[4]);
    cz  = (xs_c_r[0][0] == '0) && (xs_c_r[0][1] == '0) && (xs_c_r[0][2] == '0);

    if (dga_c_r && dgb_c_r) begin
      degh_nxt = eqab_c_r;
    end else if (dga_c_r) begin
      degh_nxt = os1;
    end else begin
      degh_nxt = os3;
    end
    parh_nxt = os1 || os2 || os3;
    for (int i = 0; i < 3; i++) begin
      degpt_nxt[i] = dga_c_r ? asf_c_r[i] : bsf_c_r[i];
      if (os1) begin
        parpt_nxt[i] = asf_c_r[i];
      end else if (os2) begin
        parpt_nxt[i] = aef_c_r[i];
      end else begin
        parpt_nxt[i] = bsf_c_r[i];
      end
    end

    if (xs_c_r[0][0] != '0) begin
      k = 2'd0;
    end else if (xs_c_r[0][1] != '0) begin
      k = 2'd1;
    end else begin
      k = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else begin
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cd_d_r[i]    <= CDW'(xs_c_r[0][i]) * CDW'(d3_c_r[i]);
      degpt_d_r[i] <= degpt_nxt[i];
      parpt_d_r[i] <= parpt_nxt[i];
      bsf_d_r[i]   <= bsf_c_r[i];
      m_d_r[i]     <= m_c_r[i];
    end
    deg_d_r  <= dga_c_r || dgb_c_r;
    degh_d_r <= degh_nxt;
    cz_d_r   <= cz;
    parh_d_r <= parh_nxt;
    den_d_r  <= xs_c_r[0][k];
    num_d_r  <= xs_c_r[1][k];
    snum_d_r <= xs_c_r[2][k];
    neg_d_r  <= neg_c_r;
  end

  // --------------------------------------------------------------------------
  // stage E: coplanarity sum, case decision, sign normalization
  // --------------------------------------------------------------------------
  logic signed [CSW-1:0]  cdot;
  logic                   dflip;

  logic                   vld_e_r;
  logic                   gen_e_r, hit_e_r;
  logic signed [PW32-1:0] pt_e_r [3], bsf_e_r [3];
  logic signed [XW-1:0]   den_e_r, num_e_r, snum_e_r;
  logic [CW-1:0]          m_e_r [3];
  logic [2:0]             neg_e_r;

  assign cdot  = CSW'(cd_d_r[0]) + CSW'(cd_d_r[1]) + CSW'(cd_d_r[2]);
  assign dflip = den_d_r[XW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
    end else begin
      vld_e_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    gen_e_r <= !deg_d_r && (cdot == '0) && !cz_d_r;
    if (deg_d_r) begin
      hit_e_r <= degh_d_r;
    end else if (cdot != '0) begin
      hit_e_r <= 1'b0;
    end else begin
      hit_e_r <= parh_d_r;
    end
    for (int i = 0; i < 3; i++) begin
      pt_e_r[i]  <= deg_d_r ? degpt_d_r[i] : parpt_d_r[i];
      bsf_e_r[i] <= bsf_d_r[i];
      m_e_r[i]   <= m_d_r[i];
    end
    den_e_r  <= dflip ? -den_d_r  : den_d_r;
    num_e_r  <= dflip ? -num_d_r  : num_d_r;
    snum_e_r <= dflip ? -snum_d_r : snum_d_r;
    neg_e_r  <= neg_d_r;
  end

  // --------------------------------------------------------------------------
  // stage F: parameter range test and dividend products
  // --------------------------------------------------------------------------
  logic                   in_rng;
  logic                   vld_f_r;
  sid_pkg::side_t         side_f_r;
  logic [UW-1:0]          den_f_r;
  logic [sid_pkg::AXES-1:0][PRW-1:0] prod_f_r;

  assign in_rng = (num_e_r >= 0) && (num_e_r <= den_e_r) &&
                  (snum_e_r >= 0) && (snum_e_r <= den_e_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_f_r <= 1'b0;
    end else begin
      vld_f_r <= vld_e_r;
    end
  end

  always_ff @(posedge clk) begin
    side_f_r.gen <= gen_e_r;
    side_f_r.hit <= gen_e_r ? in_rng : hit_e_r;
    side_f_r.neg <= neg_e_r;
    for (int i = 0; i < 3; i++) begin
      side_f_r.pt[i]  <= pt_e_r[i];
      side_f_r.bsf[i] <= bsf_e_r[i];
      prod_f_r[i]     <= PRW'(num_e_r[UW-1:0]) * PRW'(m_e_r[i]);
    end
    den_f_r <= den_e_r[UW-1:0];
  end

  assign out_vld  = vld_f_r;
  assign out_side = side_f_r;
  assign out_den  = den_f_r;
  assign out_prod = prod_f_r;

endmodule

### design/sid_div.sv
// ----------------------------------------------------------------------------
// sid_div: pipelined restoring divider, three lanes sharing one divisor
// One quotient bit per stage; computes floor(prod * 2^FW / den) per lane.
// ----------------------------------------------------------------------------
module sid_div #(
  parameter int CW = 16,
  parameter int FW = 16,
  localparam int UW  = 2 * (CW + 1),
  localparam int PRW = UW + CW,
  localparam int QW  = CW + FW
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  sid_pkg::side_t                       in_side,
  input  logic [UW-1:0]                        in_den,
  input  logic [sid_pkg::AXES-1:0][PRW-1:0]    in_prod,
  output logic                                 out_vld,
  output sid_pkg::side_t                       out_side,
  output logic [sid_pkg::AXES-1:0][QW-1:0]     out_quo
);

  localparam int NW = PRW + FW;

  // index 0 is the stage input, index j holds the result of j steps
  logic                 vld_r  [QW+1];
  sid_pkg::side_t       side_r [QW+1];
  logic [UW-1:0]        den_r  [QW+1];
  logic [UW-1:0]        rem_r  [QW+1][3];
  logic [QW-1:0]        low_r  [QW+1][3];

  // load: upper dividend bits as partial remainder, the rest as shift-in bits
  always_comb begin
    logic [NW-1:0] dvd;
    vld_r[0]  = in_vld;
    side_r[0] = in_side;
    den_r[0]  = in_den;
    for (int l = 0; l < 3; l++) begin
      dvd         = NW'(in_prod[l]) << FW;
      rem_r[0][l] = dvd[NW-1:QW];
      low_r[0][l] = dvd[QW-1:0];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [UW:0] trial [3];
    logic [UW:0] diff  [3];

    // try subtracting the divisor from the shifted remainder
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rem_r[j][l], low_r[j][l][QW-1]};
        diff[l]  = trial[l] - {1'b0, den_r[j]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    // advance remainder; shift the quotient bit in at the bottom
    always_ff @(posedge clk) begin
      side_r[j+1] <= side_r[j];
      den_r[j+1]  <= den_r[j];
      for (int l = 0; l < 3; l++) begin
        if (trial[l] >= {1'b0, den_r[j]}) begin
          rem_r[j+1][l] <= diff[l][UW-1:0];
          low_r[j+1][l] <= {low_r[j][l][QW-2:0], 1'b1};
        end else begin
          rem_r[j+1][l] <= trial[l][UW-1:0];
          low_r[j+1][l] <= {low_r[j][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_side = side_r[QW];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      out_quo[l] = low_r[QW][l];
    end
  end

endmodule

### design/segment_intersect_3d_top.sv
// ----------------------------------------------------------------------------
// segment_intersect_3d_top: exact 3D segment/segment meeting test
// Streams one segment pair per cycle and returns hit plus a fixed-point point.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | beat
//  in_      | input     | start high, busy low   | A and B endpoints, 12 x 16 bit
//  out_     | output    | out_valid, one cycle   | hit, point x/y/z, 3 x 32 bit
//
//  One beat is accepted every cycle; busy is held low.
//  The pipeline has six geometry stages, one divider stage per quotient
//  bit and one output stage. Reset clears only the valid bits; the receiver
//  cannot stall, so results leave in order on fixed latency.
// ----------------------------------------------------------------------------
module segment_intersect_3d_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [sid_pkg::IN_W-1:0] in_a_start_x,
  input  logic signed [sid_pkg::IN_W-1:0] in_a_start_y,
  input  logic signed [sid_pkg::IN_W-1:0] in_a_start_z,
  input  logic signed [sid_pkg::IN_W-1:0] in_a_end_x,
  input  logic signed [sid_pkg::IN_W-1:0] in_a_end_y,
  input  logic signed [sid_pkg::IN_W-1:0] in_a_end_z,
  input  logic signed [sid_pkg::IN_W-1:0] in_b_start_x,
  input  logic signed [sid_pkg::IN_W-1:0] in_b_start_y,
  input  logic signed [sid_pkg::IN_W-1:0] in_b_start_z,
  input  logic signed [sid_pkg::IN_W-1:0] in_b_end_x,
  input  logic signed [sid_pkg::IN_W-1:0] in_b_end_y,
  input  logic signed [sid_pkg::IN_W-1:0] in_b_end_z,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic signed [sid_pkg::PT_W-1:0] out_point_x,
  output logic signed [sid_pkg::PT_W-1:0] out_point_y,
  output logic signed [sid_pkg::PT_W-1:0] out_point_z
);

  localparam int UW  = 2 * (COORD_BITS + 1);
  localparam int PRW = UW + COORD_BITS;
  localparam int QW  = COORD_BITS + FRAC_BITS;
  localparam int PTW = sid_pkg::PT_W;

  logic [3:0][sid_pkg::AXES-1:0][sid_pkg::IN_W-1:0] pts;
  logic                                     fr_vld, dv_vld;
  sid_pkg::side_t                           fr_side, dv_side;
  logic [UW-1:0]                            fr_den;
  logic [sid_pkg::AXES-1:0][PRW-1:0]        fr_prod;
  logic [sid_pkg::AXES-1:0][QW-1:0]         dv_quo;

  // the pipeline never stalls
  assign busy = 1'b0;

  assign pts[0] = {in_a_start_z, in_a_start_y, in_a_start_x};
  assign pts[1] = {in_a_end_z,   in_a_end_y,   in_a_end_x};
  assign pts[2] = {in_b_start_z, in_b_start_y, in_b_start_x};
  assign pts[3] = {in_b_end_z,   in_b_end_y,   in_b_end_x};

  sid_front #(
    .CW (COORD_BITS),
    .FW (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_pts   (pts),
    .out_vld  (fr_vld),
    .out_side (fr_side),
    .out_den  (fr_den),
    .out_prod (fr_prod)
  );

  sid_div #(
    .CW (COORD_BITS),
    .FW (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_side  (fr_side),
    .in_den   (fr_den),
    .in_prod  (fr_prod),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_quo  (dv_quo)
  );

  // apply the sign of dB and add B.start to divider points, pass other points through, zero the point on a miss
  logic [PTW-1:0] pnt_nxt [3];
  logic [PTW-1:0] mag     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = PTW'(dv_quo[i]);
      if (!dv_side.hit) begin
        pnt_nxt[i] = '0;
      end else if (dv_side.gen) begin
        pnt_nxt[i] = dv_side.neg[i] ? dv_side.bsf[i] - mag[i]
                                    : dv_side.bsf[i] + mag[i];
      end else begin
        pnt_nxt[i] = dv_side.pt[i];
      end
    end
  end

  logic           out_valid_r;
  logic           out_hit_r;
  logic [PTW-1:0] pnt_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= dv_side.hit;
    for (int i = 0; i < 3; i++) begin
      pnt_r[i] <= pnt_nxt[i];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_point_x = pnt_r[0];
  assign out_point_y = pnt_r[1];
  assign out_point_z = pnt_r[2];

endmodule
